[rtl/compacting_symbol_table_macros.svh]
// Assertion macros shared by the symbol table RTL.
`ifndef COMPACTING_SYMBOL_TABLE_MACROS_SVH
`define COMPACTING_SYMBOL_TABLE_MACROS_SVH

`ifndef ASSERT_OFF

`define CST_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define CST_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define CST_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CST_ASSERT(name, clk, rst, prop, msg)
`define CST_ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`define CST_ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/cst_pkg.sv]
// Shared types and codes of the compacting symbol table.
package cst_pkg;

   typedef logic [1:0] op_type;
   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_SEARCH = 2'd1;
   localparam op_type OP_DELETE = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_DUP      = 2'd1;
   localparam status_type ST_NOTFOUND = 2'd2;
   localparam status_type ST_FULL     = 2'd3;

   localparam int SLOT_W = 7;
   localparam int FILL_W = 8;

   typedef struct packed {
      logic [63:0] key;
      logic [63:0] type_tag;
      logic [15:0] byte_size;
      logic [15:0] line_number;
   } entry_rec_type;

endpackage

[rtl/cst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cst_ram #(
   parameter int WIDTH = 160,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/compacting_symbol_table.sv]
// Compacting symbol table: linear search over a packed entry RAM.
//
// Command channel: drive req_* and raise start; the item is taken at a
// clock edge where start is high and busy is low. busy stays high while
// the item is worked on. Exactly one result follows each item: rsp_valid
// is high for one cycle with rsp_status, rsp_slot and rsp_fill.
// The receiver cannot stall; the result must be taken in that cycle.
//
// Entries live in one RAM (key, type, size, line) with one read and one
// write port; all work goes through that RAM, one entry per cycle.
// Search and insert scan from entry 0 and stop at a hit. Delete scans to
// the hit and then moves each later entry down one place, one per cycle.
// A new item may be started in the cycle the result strobe is high.
//
// Reset empties the table (fill becomes zero); the RAM is not cleared,
// since only entries below the fill count are ever read.
module compacting_symbol_table
   import cst_pkg::*;
#(
   parameter int ENTRIES = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_operation,
   input  logic [63:0]         req_key,
   input  logic [63:0]         req_type_tag,
   input  logic [15:0]         req_byte_size,
   input  logic [15:0]         req_line_number,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [FILL_W-1:0]   rsp_fill
);

`include "compacting_symbol_table_macros.svh"

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int EW = $bits(entry_rec_type);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_SHIFT  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       wr_ff, wr_in;
   logic [CW-1:0]       hit_ff, hit_in;
   logic                pend_ff, pend_in;
   op_type              op_ff, op_in;
   entry_rec_type       item_ff, item_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [FILL_W-1:0]   rsp_fill_ff, rsp_fill_in;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   entry_rec_type       ram_wdata;
   logic                ram_re;
   entry_rec_type       ram_rdata;
   logic [EW-1:0]       ram_rdata_raw;

   cst_ram #(
      .WIDTH (EW),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_rdata_raw)
   );

   assign ram_rdata = entry_rec_type'(ram_rdata_raw);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      wr_in         = wr_ff;
      hit_in        = hit_ff;
      pend_in       = 1'b0;
      op_in         = op_ff;
      item_in       = item_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = item_ff;
      ram_re        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in                = req_operation;
               item_in.key          = req_key;
               item_in.type_tag     = req_type_tag;
               item_in.byte_size    = req_byte_size;
               item_in.line_number  = req_line_number;
               idx_in               = '0;
               state_in             = S_SEARCH;
            end
         end
         S_SEARCH: begin
            priority if (pend_ff && (ram_rdata.key == item_ff.key)) begin
               // matching entry sits one behind the read pointer
               unique case (op_ff)
                  OP_DELETE: begin
                     hit_in   = idx_ff - CW'(1);
                     state_in = S_SHIFT;
                  end
                  OP_SEARCH: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_slot_in   = SLOT_W'(idx_ff - CW'(1));
                     state_in      = S_IDLE;
                  end
                  OP_INSERT: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_DUP;
                     rsp_slot_in   = '0;
                     state_in      = S_IDLE;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_NOTFOUND;
                     rsp_slot_in   = '0;
                     state_in      = S_IDLE;
                  end
               endcase
            end else if (idx_ff == count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOTFOUND;
               rsp_slot_in   = '0;
               state_in      = S_IDLE;
               if (op_ff == OP_INSERT) begin
                  if (count_ff == CW'(ENTRIES)) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     // append at the end
                     ram_we        = 1'b1;
                     ram_waddr     = count_ff[AW-1:0];
                     count_in      = count_ff + CW'(1);
                     rsp_status_in = ST_OK;
                     rsp_slot_in   = SLOT_W'(count_ff);
                  end
               end
            end else begin
               ram_re  = 1'b1;
               pend_in = 1'b1;
               idx_in  = idx_ff + CW'(1);
            end
         end
         S_SHIFT: begin
            // write back the entry read last cycle one place lower
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = wr_ff[AW-1:0];
               ram_wdata = ram_rdata;
            end
            if (idx_ff < count_ff) begin
               ram_re  = 1'b1;
               pend_in = 1'b1;
               wr_in   = idx_ff - CW'(1);
               idx_in  = idx_ff + CW'(1);
            end else if (!pend_ff) begin
               count_in      = count_ff - CW'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_slot_in   = SLOT_W'(hit_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_fill_in = FILL_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      wr_ff         <= wr_in;
      hit_ff        <= hit_in;
      op_ff         <= op_in;
      item_ff       <= item_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_fill   = rsp_fill_ff;

   `CST_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(ENTRIES),
      "fill count above capacity")
   `CST_ASSERT_IMPL(a_rsp_idle, clock, reset, rsp_valid, !busy, "result strobe while busy")
   `CST_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy,
      "accepted item did not raise busy")
   `CST_ASSERT_IMPL(a_fail_keeps_fill, clock, reset, rsp_valid && (rsp_status != ST_OK),
      $stable(count_ff), "failed item changed fill count")

endmodule
